/* hw/rtl/pi_fan_switch_controller_top_defines.svh */
// assertion macros shared by the controller rtl
`ifndef PI_FAN_SWITCH_CONTROLLER_TOP_DEFINES_SVH
`define PI_FAN_SWITCH_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold in every cycle out of reset
`define PIFSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked against the following cycle
`define PIFSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PIFSC_ASSERT(label, clk, rst, prop, msg)

`define PIFSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* hw/rtl/pifsc_pkg.sv */
package pifsc_pkg;

   // field and datapath widths
   localparam int TEMP_W  = 18;
   localparam int ERR_W   = 19;
   localparam int GAIN_W  = 16;
   localparam int LIM_W   = 40;
   localparam int BAND_W  = 17;
   localparam int INTG_W  = 41;
   localparam int ACC_W   = 58;
   localparam int CNT_W   = 4;
   localparam int SWCNT_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 40;

   // scale shift of the proportional term against the integral term
   localparam int PROP_SHIFT = 8;

   // last bit of the serial multiplier, the sign bit for signed gains
   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(GAIN_W - 1);

   // action codes
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_TOGGLE = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   // led mode codes
   localparam logic [1:0] LED_OFF    = 2'd0;
   localparam logic [1:0] LED_BLINK  = 2'd1;
   localparam logic [1:0] LED_STEADY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND       = 3'd4;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INTEG,
      ST_CLAMP,
      ST_PROP,
      ST_LOAD_I,
      ST_IGAIN,
      ST_DECIDE
   } state_type;

   // command to the serial multiply-accumulate unit
   typedef struct packed {
      logic load;
      logic keep;
      logic step;
      logic neg;
   } mac_cmd_type;

endpackage

/* hw/rtl/pi_fan_switch_controller_top.sv */
// channel   | ports                                          | direction
// ----------+------------------------------------------------+----------
// request   | req_valid, req_stall, req_action, req_*_temp   | in
// response  | rsp_valid, rsp_stall, rsp_fan_on .. rsp_switch | out
// registers | csr_write, csr_index, csr_data                 | in
//
// toggle, tick and unused actions bypass the sequencer; their response is
// registered when taken. a sample runs one bit-serial shift-add unit 16 steps
// each for error times period, proportional and integral gain. synchronous
// reset clears all but the error and mac registers; no clearing pass needed.
// a new request is taken only when idle and the response register is free
// or being emptied in the same cycle.

`include "pi_fan_switch_controller_top_defines.svh"

module pi_fan_switch_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic signed [pifsc_pkg::TEMP_W-1:0] req_measured_temp,
   input  logic signed [pifsc_pkg::TEMP_W-1:0] req_target_temp,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_fan_on,
   output logic                                rsp_control_enabled,
   output logic                                rsp_in_band,
   output logic [1:0]                          rsp_led_mode,
   output logic                                rsp_led_level,
   output logic [pifsc_pkg::SWCNT_W-1:0]       rsp_switch_count,
   input  logic                                csr_write,
   input  logic [pifsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pifsc_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam int ACC_W  = pifsc_pkg::ACC_W;
   localparam int ERR_W  = pifsc_pkg::ERR_W;
   localparam int INTG_W = pifsc_pkg::INTG_W;
   localparam int LIM_W  = pifsc_pkg::LIM_W;
   localparam int BAND_W = pifsc_pkg::BAND_W;
   localparam int GAIN_W = pifsc_pkg::GAIN_W;

   // configuration registers
   logic [GAIN_W-1:0] prop_gain_ff;
   logic [GAIN_W-1:0] integral_gain_ff;
   logic [GAIN_W-1:0] sample_period_ff;
   logic [LIM_W-1:0]  integral_limit_ff;
   logic [BAND_W-1:0] deadband_ff;

   // controller state
   pifsc_pkg::state_type state_ff, state_in;
   logic [pifsc_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [INTG_W-1:0]      integrator_ff;
   logic signed [ERR_W-1:0]       err_ff;
   logic                          fan_ff;
   logic                          enable_ff;
   logic [1:0]                    led_mode_ff;
   logic                          blink_ff;
   logic                          led_ff;
   logic                          band_ff;
   logic [pifsc_pkg::SWCNT_W-1:0] swcnt_ff;
   logic                          rsp_valid_ff, rsp_valid_in;

   // handshake terms
   logic out_free;
   logic req_take;
   logic take_sample;
   logic take_other;
   logic finish;
   logic step_last;

   // datapath
   logic signed [ERR_W-1:0]  err_in;
   pifsc_pkg::mac_cmd_type   mac_cmd;
   logic [ACC_W-1:0]         mac_init;
   logic [ACC_W-1:0]         mac_mcand;
   logic [GAIN_W-1:0]        mac_mplier;
   logic [ACC_W-1:0]         mac_acc;
   logic signed [ACC_W-1:0]  acc_s;
   logic signed [ACC_W-1:0]  lim_pos;
   logic signed [ACC_W-1:0]  lim_neg;
   logic signed [INTG_W-1:0] clamp_val;
   logic [ERR_W-1:0]         err_mag;
   logic                     in_band;
   logic                     drive_pos;
   logic                     intg_ok;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = !((state_ff == pifsc_pkg::ST_IDLE) && out_free);
   assign req_take    = req_valid && !req_stall;
   assign take_sample = req_take && (req_action == pifsc_pkg::ACT_SAMPLE);
   assign take_other  = req_take && (req_action != pifsc_pkg::ACT_SAMPLE);
   assign finish      = (state_ff == pifsc_pkg::ST_DECIDE) && out_free;
   assign step_last   = (cnt_ff == pifsc_pkg::STEP_LAST);

   // error from the request fields
   assign err_in = ERR_W'(req_target_temp) - ERR_W'(req_measured_temp);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff      <= GAIN_W'(256);
         integral_gain_ff  <= '0;
         sample_period_ff  <= GAIN_W'(256);
         integral_limit_ff <= '0;
         deadband_ff       <= BAND_W'(500);
      end else if (csr_write) begin
         unique case (csr_index)
            pifsc_pkg::CSR_PROP_GAIN:      prop_gain_ff      <= csr_data[GAIN_W-1:0];
            pifsc_pkg::CSR_INTEGRAL_GAIN:  integral_gain_ff  <= csr_data[GAIN_W-1:0];
            pifsc_pkg::CSR_SAMPLE_PERIOD:  sample_period_ff  <= csr_data[GAIN_W-1:0];
            pifsc_pkg::CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_data[LIM_W-1:0];
            pifsc_pkg::CSR_DEADBAND:       deadband_ff       <= csr_data[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pifsc_pkg::ST_IDLE:   if (take_sample) state_in = pifsc_pkg::ST_INTEG;
         pifsc_pkg::ST_INTEG:  if (step_last) state_in = pifsc_pkg::ST_CLAMP;
         pifsc_pkg::ST_CLAMP:  state_in = pifsc_pkg::ST_PROP;
         pifsc_pkg::ST_PROP:   if (step_last) state_in = pifsc_pkg::ST_LOAD_I;
         pifsc_pkg::ST_LOAD_I: state_in = pifsc_pkg::ST_IGAIN;
         pifsc_pkg::ST_IGAIN:  if (step_last) state_in = pifsc_pkg::ST_DECIDE;
         pifsc_pkg::ST_DECIDE: if (out_free) state_in = pifsc_pkg::ST_IDLE;
         default:              state_in = pifsc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: commands and operands for the shift-add unit
   always_comb begin
      mac_cmd    = '0;
      mac_init   = '0;
      mac_mcand  = '0;
      mac_mplier = '0;
      unique case (state_ff)
         pifsc_pkg::ST_IDLE: begin
            // integrator plus error times period
            mac_cmd.load = take_sample;
            mac_init     = ACC_W'(integrator_ff);
            mac_mcand    = ACC_W'(err_in);
            mac_mplier   = sample_period_ff;
         end
         pifsc_pkg::ST_INTEG: begin
            mac_cmd.step = 1'b1;
         end
         pifsc_pkg::ST_CLAMP: begin
            // proportional term scaled up to the integral term
            mac_cmd.load = 1'b1;
            mac_mcand    = ACC_W'(err_ff) <<< pifsc_pkg::PROP_SHIFT;
            mac_mplier   = prop_gain_ff;
         end
         pifsc_pkg::ST_PROP, pifsc_pkg::ST_IGAIN: begin
            mac_cmd.step = 1'b1;
            mac_cmd.neg  = step_last;
         end
         pifsc_pkg::ST_LOAD_I: begin
            mac_cmd.load = 1'b1;
            mac_cmd.keep = 1'b1;
            mac_mcand    = ACC_W'(integrator_ff);
            mac_mplier   = integral_gain_ff;
         end
         pifsc_pkg::ST_DECIDE: ;
         default: ;
      endcase
   end

   assign cnt_in = mac_cmd.step ? cnt_ff + 1'b1 : cnt_ff;

   pifsc_mac u_mac (
      .clock    (clock),
      .cmd      (mac_cmd),
      .acc_init (mac_init),
      .mcand    (mac_mcand),
      .mplier   (mac_mplier),
      .acc      (mac_acc)
   );

   // clamp of the updated integrator
   assign acc_s   = $signed(mac_acc);
   assign lim_pos = $signed({{(ACC_W-LIM_W){1'b0}}, integral_limit_ff});
   assign lim_neg = -lim_pos;

   always_comb begin
      priority if (acc_s > lim_pos) begin
         clamp_val = lim_pos[INTG_W-1:0];
      end else if (acc_s < lim_neg) begin
         clamp_val = lim_neg[INTG_W-1:0];
      end else begin
         clamp_val = acc_s[INTG_W-1:0];
      end
   end

   // deadband test and sign of the drive
   assign err_mag   = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign in_band   = err_mag <= ERR_W'(deadband_ff);
   assign drive_pos = mac_acc[ACC_W-1];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (take_other || finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         // stalled response is held
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pifsc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_sample) begin
         err_ff <= err_in;
      end
   end

   // controller state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         integrator_ff <= '0;
         fan_ff        <= 1'b0;
         enable_ff     <= 1'b0;
         led_mode_ff   <= pifsc_pkg::LED_OFF;
         blink_ff      <= 1'b1;
         led_ff        <= 1'b0;
         band_ff       <= 1'b0;
         swcnt_ff      <= '0;
      end else begin
         if (state_ff == pifsc_pkg::ST_CLAMP) begin
            integrator_ff <= clamp_val;
         end
         // toggle and tick transfers
         if (take_other) begin
            unique case (req_action)
               pifsc_pkg::ACT_TOGGLE: begin
                  enable_ff <= !enable_ff;
                  if (enable_ff) begin
                     fan_ff <= 1'b0;
                  end
               end
               pifsc_pkg::ACT_TICK: begin
                  unique case (led_mode_ff)
                     pifsc_pkg::LED_BLINK:  led_ff <= blink_ff;
                     pifsc_pkg::LED_STEADY: led_ff <= 1'b1;
                     default:               led_ff <= 1'b0;
                  endcase
                  blink_ff <= !blink_ff;
               end
               default: ;
            endcase
         end
         // end of a sample: fan decision and led mode
         if (finish) begin
            band_ff <= in_band;
            if (!in_band) begin
               if (drive_pos) begin
                  if (!fan_ff) begin
                     fan_ff   <= enable_ff;
                     swcnt_ff <= swcnt_ff + 1'b1;
                  end
               end else if (enable_ff) begin
                  fan_ff <= 1'b0;
               end
            end
            if (enable_ff) begin
               led_mode_ff <= in_band ? pifsc_pkg::LED_STEADY : pifsc_pkg::LED_BLINK;
            end else begin
               led_mode_ff <= pifsc_pkg::LED_OFF;
            end
         end
      end
   end

   // state only moves when the response slot turns over, so it is the payload
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fan_on          = fan_ff;
   assign rsp_control_enabled = enable_ff;
   assign rsp_in_band         = band_ff;
   assign rsp_led_mode        = led_mode_ff;
   assign rsp_led_level       = led_ff;
   assign rsp_switch_count    = swcnt_ff;

   // integrator held within the clamp right after it is written
   assign intg_ok = (ACC_W'(integrator_ff) <= lim_pos)
                    && (ACC_W'(integrator_ff) >= lim_neg);

   `PIFSC_ASSERT_NEXT(a_sample_starts, clock, reset, take_sample,
      state_ff == pifsc_pkg::ST_INTEG, "sample transfer did not start the sequence")
   `PIFSC_ASSERT_NEXT(a_clamp_holds, clock, reset, state_ff == pifsc_pkg::ST_CLAMP,
      intg_ok, "integrator outside its limit after clamp")
   `PIFSC_ASSERT(a_no_rsp_busy, clock, reset,
      (state_ff == pifsc_pkg::ST_IDLE) || (state_ff == pifsc_pkg::ST_DECIDE) || !rsp_valid_ff,
      "response pending while a sample is in progress")
   `PIFSC_ASSERT(a_fan_needs_enable, clock, reset, !fan_ff || enable_ff,
      "fan on while control is disabled")

endmodule

/* hw/rtl/pifsc_mac.sv */
module pifsc_mac (
   input  logic                             clock,
   input  pifsc_pkg::mac_cmd_type           cmd,
   input  logic [pifsc_pkg::ACC_W-1:0]      acc_init,
   input  logic [pifsc_pkg::ACC_W-1:0]      mcand,
   input  logic [pifsc_pkg::GAIN_W-1:0]     mplier,
   output logic [pifsc_pkg::ACC_W-1:0]      acc
);

   logic [pifsc_pkg::ACC_W-1:0]  acc_ff;
   logic [pifsc_pkg::ACC_W-1:0]  acc_in;
   logic [pifsc_pkg::ACC_W-1:0]  mcand_ff;
   logic [pifsc_pkg::ACC_W-1:0]  mcand_in;
   logic [pifsc_pkg::GAIN_W-1:0] mplier_ff;
   logic [pifsc_pkg::GAIN_W-1:0] mplier_in;
   logic [pifsc_pkg::ACC_W-1:0]  addend;

   // partial product of the current multiplier bit, negated for a sign bit
   assign addend = (mcand_ff ^ {pifsc_pkg::ACC_W{cmd.neg}})
                   + {{(pifsc_pkg::ACC_W-1){1'b0}}, cmd.neg};

   // load or one shift-add step
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      priority if (cmd.load) begin
         if (!cmd.keep) begin
            acc_in = acc_init;
         end
         mcand_in  = mcand;
         mplier_in = mplier;
      end else if (cmd.step) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + addend;
         end
         mcand_in  = {mcand_ff[pifsc_pkg::ACC_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[pifsc_pkg::GAIN_W-1:1]};
      end else begin
         // hold
         acc_in    = acc_ff;
         mcand_in  = mcand_ff;
         mplier_in = mplier_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign acc = acc_ff;

endmodule

/* dv/pi_fan_switch_controller_checker.sv */
module pi_fan_switch_controller_checker
   import pifsc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [1:0]                 req_action,
   input  logic signed [TEMP_W-1:0]   req_measured_temp,
   input  logic signed [TEMP_W-1:0]   req_target_temp,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_fan_on,
   input  logic                       rsp_control_enabled,
   input  logic                       rsp_in_band,
   input  logic [1:0]                 rsp_led_mode,
   input  logic                       rsp_led_level,
   input  logic [SWCNT_W-1:0]         rsp_switch_count,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DAT_W-1:0]       csr_data,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic               fan_on;
      logic               control_enabled;
      logic               in_band;
      logic [1:0]         led_mode;
      logic               led_level;
      logic [SWCNT_W-1:0] switch_count;
   } fan_status_t;

   // shadow copy of the registers
   logic signed [GAIN_W-1:0] cfg_kp;
   logic signed [GAIN_W-1:0] cfg_ki;
   logic [GAIN_W-1:0]        cfg_period;
   logic [LIM_W-1:0]         cfg_limit;
   logic [BAND_W-1:0]        cfg_band;

   // shadow copy of the controller state
   longint             integ_acc;
   logic               fan_drv;
   logic               ctl_en;
   logic [1:0]         led_sel;
   logic               blink_ph;
   logic               led_pin;
   logic               band_hit;
   logic [SWCNT_W-1:0] turn_ons;

   // status words still owed by the block, oldest first
   fan_status_t status_due[$];

   // advance the shadow state by one request and return the status it leaves
   function automatic fan_status_t status_after(input logic [1:0] act,
                                                input logic signed [TEMP_W-1:0] meas,
                                                input logic signed [TEMP_W-1:0] targ);
      longint      err;
      longint      acc;
      longint      lim;
      longint      drive;
      longint      mag;
      fan_status_t s;
      case (act)
         ACT_SAMPLE: begin
            err = longint'(targ) - longint'(meas);
            acc = integ_acc + err * longint'(cfg_period);
            lim = longint'(cfg_limit);
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            integ_acc = acc;
            drive = -(longint'(cfg_kp) * err) * 256 - longint'(cfg_ki) * integ_acc;
            mag = (err < 0) ? -err : err;
            band_hit = (mag <= longint'(cfg_band));
            // fan decision only outside the band; turn-ons count even when disabled
            if (!band_hit) begin
               if (drive > 0) begin
                  if (!fan_drv) begin
                     if (ctl_en) fan_drv = 1'b1;
                     turn_ons = turn_ons + 1'b1;
                  end
               end else if (fan_drv && ctl_en) begin
                  fan_drv = 1'b0;
               end
            end
            if (!ctl_en) led_sel = LED_OFF;
            else if (band_hit) led_sel = LED_STEADY;
            else led_sel = LED_BLINK;
         end
         ACT_TOGGLE: begin
            ctl_en = !ctl_en;
            if (!ctl_en) fan_drv = 1'b0;
         end
         ACT_TICK: begin
            case (led_sel)
               LED_BLINK:  led_pin = blink_ph;
               LED_STEADY: led_pin = 1'b1;
               default:    led_pin = 1'b0;
            endcase
            blink_ph = !blink_ph;
         end
         default: ;
      endcase
      s.fan_on          = fan_drv;
      s.control_enabled = ctl_en;
      s.in_band         = band_hit;
      s.led_mode        = led_sel;
      s.led_level       = led_pin;
      s.switch_count    = turn_ons;
      return s;
   endfunction

   task automatic check_field(input string name, input logic [SWCNT_W-1:0] want,
                              input logic [SWCNT_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, name, want, got);
      end
   endtask

   // sample at the falling edge what the next rising edge will transfer
   always @(negedge clock) begin
      fan_status_t got;
      fan_status_t want;
      if (reset) begin
         cfg_kp     = 16'sd256;
         cfg_ki     = '0;
         cfg_period = 16'd256;
         cfg_limit  = '0;
         cfg_band   = 17'd500;
         integ_acc  = 0;
         fan_drv    = 1'b0;
         ctl_en     = 1'b0;
         led_sel    = LED_OFF;
         blink_ph   = 1'b1;
         led_pin    = 1'b0;
         band_hit   = 1'b0;
         turn_ons   = '0;
         fail_count = 0;
         status_due.delete();
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CSR_PROP_GAIN:      cfg_kp     = csr_data[GAIN_W-1:0];
               CSR_INTEGRAL_GAIN:  cfg_ki     = csr_data[GAIN_W-1:0];
               CSR_SAMPLE_PERIOD:  cfg_period = csr_data[GAIN_W-1:0];
               CSR_INTEGRAL_LIMIT: cfg_limit  = csr_data[LIM_W-1:0];
               CSR_DEADBAND:       cfg_band   = csr_data[BAND_W-1:0];
               default: ;
            endcase
         end
         // response transfer against the oldest owed status
         if (rsp_valid && !rsp_stall) begin
            got.fan_on          = rsp_fan_on;
            got.control_enabled = rsp_control_enabled;
            got.in_band         = rsp_in_band;
            got.led_mode        = rsp_led_mode;
            got.led_level       = rsp_led_level;
            got.switch_count    = rsp_switch_count;
            if (status_due.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: response with nothing outstanding", $realtime);
            end else begin
               want = status_due.pop_front();
               check_field("fan_on", want.fan_on, got.fan_on);
               check_field("control_enabled", want.control_enabled, got.control_enabled);
               check_field("in_band", want.in_band, got.in_band);
               check_field("led_mode", want.led_mode, got.led_mode);
               check_field("led_level", want.led_level, got.led_level);
               check_field("switch_count", want.switch_count, got.switch_count);
            end
         end
         // request transfer
         if (req_valid && !req_stall)
            status_due.push_back(status_after(req_action, req_measured_temp, req_target_temp));
      end
      pending = status_due.size();
   end

endmodule

/* dv/pi_fan_switch_controller_top_tb.sv */
module pi_fan_switch_controller_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pifsc_pkg::*;

   localparam int CLK_HIGH      = 4;
   localparam int CLK_LOW       = 4;
   localparam int RESET_CYCLES  = 9;
   localparam int IDLE_PCT      = 33;
   localparam int PHASE_ITEMS   = 75;
   localparam int PHASES        = 6;
   localparam int QUIET_PHASE   = 3;
   localparam int DRAIN_CYCLES  = 64;
   localparam int CYCLE_LIMIT   = 300000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 3'd5;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_action = ACT_SAMPLE;
   logic signed [TEMP_W-1:0]  req_measured_temp = '0;
   logic signed [TEMP_W-1:0]  req_target_temp = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_fan_on;
   logic                      rsp_control_enabled;
   logic                      rsp_in_band;
   logic [1:0]                rsp_led_mode;
   logic                      rsp_led_level;
   logic [SWCNT_W-1:0]        rsp_switch_count;
   logic                      csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DAT_W-1:0]      csr_data = '0;

   int fail_count;
   int pending;
   int cycles = 0;
   bit quiet = 1'b0;

   pi_fan_switch_controller_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_measured_temp   (req_measured_temp),
      .req_target_temp     (req_target_temp),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_fan_on          (rsp_fan_on),
      .rsp_control_enabled (rsp_control_enabled),
      .rsp_in_band         (rsp_in_band),
      .rsp_led_mode        (rsp_led_mode),
      .rsp_led_level       (rsp_led_level),
      .rsp_switch_count    (rsp_switch_count),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   pi_fan_switch_controller_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_measured_temp   (req_measured_temp),
      .req_target_temp     (req_target_temp),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_fan_on          (rsp_fan_on),
      .rsp_control_enabled (rsp_control_enabled),
      .rsp_in_band         (rsp_in_band),
      .rsp_led_mode        (rsp_led_mode),
      .rsp_led_level       (rsp_led_level),
      .rsp_switch_count    (rsp_switch_count),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   // clock
   always begin
      #CLK_HIGH clock = 1'b1;
      #CLK_LOW  clock = 1'b0;
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset || quiet) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99, 0) < IDLE_PCT);
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("pi_fan_switch_controller_top regression: fail");
         $finish;
      end
   end

   // one request transfer, with random gaps in front of it
   task automatic send_item(input logic [1:0] act, input int meas, input int targ);
      while (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_measured_temp <= TEMP_W'(meas);
      req_target_temp   <= TEMP_W'(targ);
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   // let every owed response come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
   endtask

   // full register set plus one write to an unused index
   task automatic apply_settings(input logic signed [GAIN_W-1:0] kp,
                                 input logic signed [GAIN_W-1:0] ki,
                                 input logic [GAIN_W-1:0] period,
                                 input logic [LIM_W-1:0] limit,
                                 input logic [BAND_W-1:0] band);
      write_reg(CSR_PROP_GAIN, CSR_DAT_W'(kp));
      write_reg(CSR_INTEGRAL_GAIN, CSR_DAT_W'(ki));
      write_reg(CSR_SAMPLE_PERIOD, CSR_DAT_W'(period));
      write_reg(CSR_INTEGRAL_LIMIT, CSR_DAT_W'(limit));
      write_reg(CSR_DEADBAND, CSR_DAT_W'(band));
      write_reg(CSR_FIRST_UNUSED + CSR_IDX_W'($urandom_range(2, 0)),
                CSR_DAT_W'({$urandom, $urandom}));
      csr_write <= 1'b0;
   endtask

   initial begin
      int pick;
      int base;
      int delta;
      int meas;
      int targ;
      logic [1:0] act;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with reset settings: unity gain, no integral, band 500
      send_item(ACT_SAMPLE, 20000, 20000);
      send_item(ACT_SAMPLE, 30000, 20000);      // hot while disabled: counted, fan stays off
      send_item(ACT_TICK, 0, 0);
      send_item(ACT_TOGGLE, 0, 0);
      send_item(ACT_SAMPLE, 30000, 20000);      // hot while enabled: fan on
      send_item(ACT_TICK, 0, 0);
      send_item(ACT_TICK, 0, 0);
      send_item(ACT_TICK, 0, 0);
      send_item(ACT_SAMPLE, 20200, 20000);      // in band: fan kept, steady led
      send_item(ACT_TICK, 0, 0);
      send_item(ACT_SAMPLE, 500, 0);            // error exactly on the band edge
      send_item(ACT_SAMPLE, 501, 0);            // just outside the band
      send_item(ACT_SAMPLE, 10000, 20000);      // cold: fan off
      send_item(ACT_SAMPLE, 131071, -131072);   // widest hot error
      send_item(ACT_TOGGLE, 0, 0);              // disable forces the fan off
      send_item(ACT_UNUSED, -1, -1);
      send_item(ACT_SAMPLE, -131072, 131071);   // widest cold error, disabled
      send_item(ACT_TICK, 0, 0);
      send_item(ACT_TOGGLE, -131072, 131071);
      send_item(ACT_SAMPLE, 131071, -131072);
      send_item(ACT_UNUSED, 131071, -131072);
      send_item(ACT_SAMPLE, 0, 0);
      send_item(ACT_TICK, 0, 0);

      // random phases, each under its own settings
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: apply_settings(16'sd256, 16'sd16, 16'd256, 40'd2000000, 17'd500);
            1: apply_settings(-16'sd32768, 16'sd32767, 16'hFFFF, {LIM_W{1'b1}}, '0);
            2: apply_settings(16'sd32767, -16'sd32768, '0, '0, {BAND_W{1'b1}});
            4: apply_settings('0, -16'sd256, 16'd128, 40'd50000, 17'd200);
            default: apply_settings(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                                    LIM_W'({$urandom, $urandom}),
                                    BAND_W'($urandom_range(4000, 0)));
         endcase
         quiet = (phase == QUIET_PHASE);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99, 0);
            if (pick < 60) act = ACT_SAMPLE;
            else if (pick < 75) act = ACT_TOGGLE;
            else if (pick < 95) act = ACT_TICK;
            else act = ACT_UNUSED;
            // mostly errors around the band, now and then the full field range
            if ($urandom_range(9, 0) == 0) begin
               meas = int'($urandom);
               targ = int'($urandom);
            end else begin
               base  = int'($urandom_range(80000, 0)) - 40000;
               delta = int'($urandom_range(6000, 0)) - 3000;
               targ  = base;
               meas  = base + delta;
            end
            send_item(act, meas, targ);
         end
      end
      quiet = 1'b0;

      // drain and settle
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("pi_fan_switch_controller_top regression: pass");
      end else begin
         $display("pi_fan_switch_controller_top regression: fail");
      end
      $finish;
   end

endmodule
